### rtl/oqt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqt_pkg
// Shared types, constants and helpers for the optimistic Q table update unit.
// ----------------------------------------------------------------------------
package oqt_pkg;

    localparam int AGENTS  = 4;
    localparam int STATES  = 1024;
    localparam int ACTIONS = 5;

    localparam int Q_DEPTH = AGENTS * STATES * ACTIONS;
    localparam int ADDR_W  = $clog2(Q_DEPTH);
    localparam int ACT_W   = $clog2(ACTIONS);
    localparam int CTR_W   = $clog2(ACTIONS + 2);

    localparam int Q_W     = 16;
    localparam int FRAC_W  = 8;
    localparam int RATE_W  = 9;
    localparam int EPS_W   = 10;
    localparam int RATE_MAX = 256;

    // shared multiplier: 10-bit rate times 26-bit operand
    localparam int MUL_A_W = RATE_W + 1;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = MUL_B_W + 1;
    localparam int SHIFT_W = 16;
    localparam int INC_W   = PROD_W - SHIFT_W;
    localparam int NEWQ_W  = INC_W + 1;
    localparam int ROUND_HALF = 32768;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [EPS_W-1:0]  EXPLORE_RESET  = 10'd100;
    localparam logic [RATE_W-1:0] LEARN_RESET    = 9'd102;
    localparam logic [RATE_W-1:0] DISCOUNT_RESET = 9'd230;

    typedef enum logic [1:0] {
        REG_EXPLORE    = 2'd0,
        REG_LEARN_RATE = 2'd1,
        REG_DISCOUNT   = 2'd2
    } oqt_reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_MUL_AR,
        ST_MUL_GM,
        ST_CMP,
        ST_MUL_AD,
        ST_WRITE,
        ST_RESCAN,
        ST_DONE
    } oqt_state_t;

    typedef struct packed {
        logic [1:0]         agent;
        logic               learn;
        logic [9:0]         cur_state;
        logic [2:0]         taken_action;
        logic signed [15:0] reward;
        logic [9:0]         next_state;
        logic               next_valid;
        logic [9:0]         explore_draw;
        logic [2:0]         explore_action;
    } oqt_item_t;

    typedef struct packed {
        logic [2:0]         next_action;
        logic signed [15:0] next_max_q;
        logic               explored;
        logic               updated;
    } oqt_result_t;

    typedef struct packed {
        logic [EPS_W-1:0]  explore_permille;
        logic [RATE_W-1:0] learn_rate;
        logic [RATE_W-1:0] discount;
    } oqt_cfg_t;

    function automatic logic [RATE_W-1:0] sat_rate(input logic [RATE_W-1:0] x);
        if (x > RATE_W'(RATE_MAX))
            return RATE_W'(RATE_MAX);
        return x;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [1:0] ag,
        input logic [9:0] st,
        input logic [2:0] act
    );
        logic [ADDR_W-1:0] row;
        row = ADDR_W'(ag) * ADDR_W'(STATES) + ADDR_W'(st);
        return row * ADDR_W'(ACTIONS) + ADDR_W'(act);
    endfunction

    // small table: 3-bit action folded into range
    function automatic logic [ACT_W-1:0] wrap_action(input logic [2:0] x);
        logic [ACT_W-1:0] res;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (x == 3'(i))
                res = ACT_W'(i % ACTIONS);
        end
        return res;
    endfunction

endpackage

### rtl/optimistic_q_table_update_select_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optimistic_q_table_update_select_unit
// Per-agent Q table with optimistic update and epsilon-greedy selection.
// ----------------------------------------------------------------------------
//  channel   signals                          transfer when
//  item      item_valid, item_stall, item     item_valid & !item_stall
//  result    result_valid, result_stall, ...  result_valid & !result_stall
//  config    psel, penable, pwrite, paddr ... psel & penable & pwrite
//
//  Items are taken one at a time, in idle. The single table port (one read or
//  write a cycle) reads the next state's row and the current entry; when
//  learning, the shared multiplier forms alpha*r and gamma*m, and a raised entry
//  takes alpha*d, is written and, if it lies in the next state's row, rescanned.
//  After reset the table is swept to zero, one entry a cycle.
//  A finished result is held in an output register; the next item is taken
//  while it waits.
// ----------------------------------------------------------------------------
module optimistic_q_table_update_select_unit
    import oqt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  oqt_item_t             item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output oqt_result_t           result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    oqt_cfg_t    cfg;
    oqt_state_t  state_reg, state_next;
    logic [CTR_W-1:0]  ctr_reg, ctr_next;
    logic [ADDR_W-1:0] clr_addr_reg;

    oqt_item_t         item_reg;
    logic              agent_ok_reg, nok_reg, learn_ok_reg, same_row_reg, explore_reg;
    logic [ACT_W-1:0]  xa_reg;
    logic [ADDR_W-1:0] next_base_reg, cur_addr_reg;
    logic [RATE_W-1:0] rate_a_reg, rate_g_reg;

    logic signed [Q_W-1:0]     row_reg [ACTIONS];
    logic signed [Q_W-1:0]     best_reg, q_reg;
    logic [ACT_W-1:0]          arg_reg;
    logic signed [MUL_B_W-1:0] p_ar_reg, d_reg;
    logic                      upd_reg;

    oqt_result_t result_reg;
    logic        result_valid_reg;

    logic item_accept, result_load;

    // table port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [Q_W-1:0]    ram_wdata, ram_rdata;

    // multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_prod;

    // scan
    logic                  scan_en;
    logic [CTR_W-1:0]      fetch_idx;
    logic [ACT_W-1:0]      scan_idx;
    logic signed [Q_W-1:0] scan_val;

    // arithmetic
    logic signed [Q_W-1:0]     m_eff, new_q;
    logic signed [MUL_B_W-1:0] p_gm;
    logic signed [SUM_W-1:0]   t_sum, q256, r256, diff;
    logic                      raise;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [INC_W-1:0]   inc;
    logic signed [NEWQ_W-1:0]  new_sum;

    oqt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    oqt_ram #(
        .DATA_W (Q_W),
        .DEPTH  (Q_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    oqt_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    assign item_accept = item_valid & ~item_stall;
    assign result_load = (state_reg == ST_DONE) & (~result_valid_reg | ~result_stall);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_addr_reg == ADDR_W'(Q_DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (item_accept)
                    state_next = (32'(item.agent) < AGENTS) ? ST_FETCH : ST_DONE;
            ST_FETCH:
                if (ctr_reg == CTR_W'(ACTIONS + 1))
                    state_next = learn_ok_reg ? ST_MUL_AR : ST_DONE;
            ST_MUL_AR:
                state_next = ST_MUL_GM;
            ST_MUL_GM:
                state_next = ST_CMP;
            ST_CMP:
                state_next = raise ? ST_MUL_AD : ST_DONE;
            ST_MUL_AD:
                state_next = ST_WRITE;
            ST_WRITE:
                state_next = (nok_reg & same_row_reg) ? ST_RESCAN : ST_DONE;
            ST_RESCAN:
                if (ctr_reg == CTR_W'(ACTIONS - 1))
                    state_next = ST_DONE;
            ST_DONE:
                if (result_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        item_stall = 1'b1;
        ram_we     = 1'b0;
        ram_addr   = cur_addr_reg;
        ram_wdata  = new_q;
        mul_a      = MUL_A_W'(rate_a_reg);
        mul_b      = d_reg;
        ctr_next   = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
                item_stall = 1'b0;
            ST_FETCH:
            begin
                ctr_next = ctr_reg + 1'b1;
                if (ctr_reg < CTR_W'(ACTIONS))
                    ram_addr = next_base_reg + ADDR_W'(ctr_reg);
            end
            ST_MUL_AR:
                mul_b = {{(MUL_B_W - Q_W){item_reg.reward[Q_W-1]}}, item_reg.reward};
            ST_MUL_GM:
            begin
                mul_a = MUL_A_W'(rate_g_reg);
                mul_b = {{(MUL_B_W - Q_W){m_eff[Q_W-1]}}, m_eff};
            end
            ST_WRITE:
                ram_we = 1'b1;
            ST_RESCAN:
                ctr_next = ctr_reg + 1'b1;
            default:
                ;
        endcase
    end

    // ---------------- max scan ----------------
    assign fetch_idx = ctr_reg - 1'b1;
    assign scan_en   = ((state_reg == ST_FETCH) && (ctr_reg != '0)
                        && (ctr_reg <= CTR_W'(ACTIONS))) || (state_reg == ST_RESCAN);
    assign scan_idx  = (state_reg == ST_FETCH) ? fetch_idx[ACT_W-1:0] : ctr_reg[ACT_W-1:0];
    assign scan_val  = (state_reg == ST_FETCH) ? $signed(ram_rdata) : row_reg[scan_idx];
    assign m_eff     = nok_reg ? best_reg : '0;

    // ---------------- update arithmetic ----------------
    assign p_gm  = mul_prod[MUL_B_W-1:0];
    assign t_sum = SUM_W'(p_ar_reg) + SUM_W'(p_gm);
    assign q256  = {{(SUM_W - Q_W - FRAC_W){q_reg[Q_W-1]}}, q_reg, {FRAC_W{1'b0}}};
    assign r256  = {{(SUM_W - Q_W - FRAC_W){item_reg.reward[Q_W-1]}}, item_reg.reward,
                    {FRAC_W{1'b0}}};
    assign raise = t_sum > q256;
    assign diff  = r256 + SUM_W'(p_gm) - q256;

    assign rounded = mul_prod + PROD_W'(ROUND_HALF);
    assign inc     = rounded[PROD_W-1:SHIFT_W];
    assign new_sum = NEWQ_W'(q_reg) + NEWQ_W'(inc);

    always_comb
    begin
        if ((new_sum[NEWQ_W-1:Q_W-1] == '0) || (new_sum[NEWQ_W-1:Q_W-1] == '1))
            new_q = new_sum[Q_W-1:0];
        else if (new_sum[NEWQ_W-1])
            new_q = {1'b1, {(Q_W - 1){1'b0}}};
        else
            new_q = {1'b0, {(Q_W - 1){1'b1}}};
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            ctr_reg          <= '0;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (result_load)
                result_valid_reg <= 1'b1;
            else if (~result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg      <= item;
            agent_ok_reg  <= 32'(item.agent) < AGENTS;
            nok_reg       <= item.next_valid & (32'(item.next_state) < STATES);
            learn_ok_reg  <= item.learn & (32'(item.cur_state) < STATES)
                             & (32'(item.taken_action) < ACTIONS);
            same_row_reg  <= item.cur_state == item.next_state;
            explore_reg   <= item.explore_draw < cfg.explore_permille;
            xa_reg        <= wrap_action(item.explore_action);
            next_base_reg <= entry_addr(item.agent, item.next_state, 3'd0);
            cur_addr_reg  <= entry_addr(item.agent, item.cur_state, item.taken_action);
            rate_a_reg    <= sat_rate(cfg.learn_rate);
            rate_g_reg    <= sat_rate(cfg.discount);
            upd_reg       <= 1'b0;
        end

        if (scan_en)
        begin
            if ((scan_idx == '0) || (scan_val > best_reg))
            begin
                best_reg <= scan_val;
                arg_reg  <= scan_idx;
            end
            if (state_reg == ST_FETCH)
                row_reg[scan_idx] <= scan_val;
        end

        if ((state_reg == ST_FETCH) && (ctr_reg == CTR_W'(ACTIONS + 1)))
            q_reg <= $signed(ram_rdata);

        if (state_reg == ST_MUL_GM)
            p_ar_reg <= mul_prod[MUL_B_W-1:0];

        if (state_reg == ST_CMP)
            d_reg <= diff[MUL_B_W-1:0];

        if (state_reg == ST_WRITE)
        begin
            upd_reg <= 1'b1;
            if (nok_reg & same_row_reg)
                row_reg[ACT_W'(item_reg.taken_action)] <= new_q;
        end

        if (result_load)
        begin
            result_reg.updated  <= agent_ok_reg & upd_reg;
            result_reg.explored <= agent_ok_reg & nok_reg & explore_reg;
            result_reg.next_max_q <= (agent_ok_reg & nok_reg) ? best_reg : '0;
            if (agent_ok_reg & nok_reg)
                result_reg.next_action <= explore_reg ? 3'(xa_reg) : 3'(arg_reg);
            else
                result_reg.next_action <= '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/oqt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqt_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module oqt_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/oqt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqt_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module oqt_mul
    import oqt_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

### rtl/oqt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqt_cfg_regs
// APB register file: exploration rate, learning rate and discount.
// ----------------------------------------------------------------------------
module oqt_cfg_regs
    import oqt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output oqt_cfg_t              cfg
);

    logic [EPS_W-1:0]  explore_reg;
    logic [RATE_W-1:0] learn_reg;
    logic [RATE_W-1:0] discount_reg;
    logic              wr_en;
    oqt_reg_idx_t      idx;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = oqt_reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            explore_reg  <= EXPLORE_RESET;
            learn_reg    <= LEARN_RESET;
            discount_reg <= DISCOUNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_EXPLORE:    explore_reg  <= pwdata[EPS_W-1:0];
                REG_LEARN_RATE: learn_reg    <= pwdata[RATE_W-1:0];
                REG_DISCOUNT:   discount_reg <= pwdata[RATE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_EXPLORE:    prdata = CFG_DATA_W'(explore_reg);
            REG_LEARN_RATE: prdata = CFG_DATA_W'(learn_reg);
            REG_DISCOUNT:   prdata = CFG_DATA_W'(discount_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.explore_permille = explore_reg;
    assign cfg.learn_rate       = learn_reg;
    assign cfg.discount         = discount_reg;

endmodule
